### sv/ahts_pkg.sv
// Shared constants, types and constant tables of the additive harmonic tone sample unit.
package ahts_pkg;

    localparam int NUM_HARMONICS   = 20;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int FREQ_W  = 32;
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 20;
    localparam int ENV_W   = 17;
    localparam int MAG_W   = 15;
    localparam int WGT_W   = 16;

    localparam int K_W     = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
    localparam int QIDX_W  = SINE_TABLE_BITS - 2;
    localparam int QSIZE   = 1 << QIDX_W;

    // Envelope breakpoints in 1/16 ms and the segments rewritten over a common divisor.
    localparam int ENV_T1     = 400;
    localparam int ENV_T2     = 1600;
    localparam int ENV_T3     = 8000;
    localparam int ENV_T4     = 24000;
    localparam int ENV_O2     = 2400;
    localparam int ENV_O3     = 14400;
    localparam int ENV_O4     = 24000;
    localparam int ENV_S1     = 102400;
    localparam int ENV_S2     = 20480;
    localparam int ENV_S3     = 1280;
    localparam int ENV_S4     = 512;
    localparam int ENV_NUM_W  = 26;
    localparam int ENV_DIV    = 625;
    localparam int ENV_SHIFT  = 26;
    localparam int ENV_RECIP  = (1 << ENV_SHIFT) / ENV_DIV;
    localparam int ENV_RCP_W  = 17;

    localparam logic [31:0] Q30_C1 = 32'd1686629713;
    localparam logic [31:0] Q30_C3 = 32'd693598668;
    localparam logic [31:0] Q30_C5 = 32'd85569306;
    localparam logic [31:0] Q30_C7 = 32'd5026995;
    localparam logic [31:0] Q30_C9 = 32'd172272;

    localparam logic [WGT_W-1:0] WEIGHT_Q16 [32] = '{
        16'd34693, 16'd11796, 16'd3539, 16'd2949, 16'd2429, 16'd2255, 16'd971, 16'd2949,
        16'd382,   16'd1041,  16'd347,  16'd486,  16'd416,  16'd451,  16'd139, 16'd139,
        16'd139,   16'd139,   16'd139,  16'd139,  16'd0,    16'd0,    16'd0,   16'd0,
        16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0
    };

    typedef logic [MAG_W-1:0] qsine_t [QSIZE];

    typedef struct packed {
        logic [FREQ_W-1:0]  base;
        logic [LEVEL_W-1:0] level;
        logic [ENV_W-1:0]   env;
    } note_t;

    // Odd Taylor polynomial of degree nine in Q30 with truncating products, rounded to Q15.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        t   = 64'(m) << (30 - QIDX_W);
        t2  = (t * t) >> 30;
        acc = 64'(Q30_C9);
        acc = 64'(Q30_C7) - ((acc * t2) >> 30);
        acc = 64'(Q30_C5) - ((acc * t2) >> 30);
        acc = 64'(Q30_C3) - ((acc * t2) >> 30);
        acc = 64'(Q30_C1) - ((acc * t2) >> 30);
        s   = (acc * t) >> 30;
        s   = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[MAG_W-1:0];
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t tab;
        for (int i = 0; i < QSIZE; i++) begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    localparam qsine_t           QSINE     = build_qsine();
    localparam logic [MAG_W-1:0] QSINE_TOP = quarter_sine(QSIZE);

endpackage

### sv/ahts_front.sv
// Front end: accepts items, forms the fundamental phase and the envelope gain.
module ahts_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ahts_pkg::FREQ_W-1:0]   s_freq_step,
    input  logic [ahts_pkg::LEVEL_W-1:0]  s_level,
    input  logic [ahts_pkg::TIME_W-1:0]   s_note_time,
    output logic                          push_valid,
    output ahts_pkg::note_t               push_data,
    input  logic                          push_ready
);

    logic en;

    logic f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;

    logic [ahts_pkg::FREQ_W-1:0]    f1_step_reg;
    logic [ahts_pkg::LEVEL_W-1:0]   f1_level_reg;
    logic [ahts_pkg::TIME_W-1:0]    f1_time_reg;

    logic [ahts_pkg::FREQ_W-1:0]    f2_base_reg;
    logic [ahts_pkg::LEVEL_W-1:0]   f2_level_reg;
    logic [ahts_pkg::ENV_NUM_W-1:0] f2_num_reg;
    logic [ahts_pkg::ENV_NUM_W-1:0] f2_num_next;

    logic [ahts_pkg::FREQ_W-1:0]    f3_base_reg;
    logic [ahts_pkg::LEVEL_W-1:0]   f3_level_reg;
    logic [ahts_pkg::ENV_NUM_W-1:0] f3_num_reg;
    logic [ahts_pkg::ENV_W-1:0]     f3_quot_reg;
    logic [ahts_pkg::ENV_W-1:0]     f3_quot_next;

    logic [ahts_pkg::FREQ_W-1:0]    f4_base_reg;
    logic [ahts_pkg::LEVEL_W-1:0]   f4_level_reg;
    logic [ahts_pkg::ENV_W-1:0]     f4_env_reg;
    logic [ahts_pkg::ENV_W-1:0]     f4_env_next;

    logic [ahts_pkg::ENV_NUM_W:0]   f3_rem;

    assign en         = !(f4_valid_reg && !push_ready);
    assign s_ready    = en;
    assign push_valid = f4_valid_reg;
    assign push_data  = '{base: f4_base_reg, level: f4_level_reg, env: f4_env_reg};

    // Each envelope segment is a slope over the common divisor.
    always_comb begin
        if (f1_time_reg < ahts_pkg::TIME_W'(ahts_pkg::ENV_T1)) begin
            f2_num_next = ahts_pkg::ENV_NUM_W'(32'(f1_time_reg) * 32'(ahts_pkg::ENV_S1));
        end else if (f1_time_reg < ahts_pkg::TIME_W'(ahts_pkg::ENV_T2)) begin
            f2_num_next = ahts_pkg::ENV_NUM_W'((32'(ahts_pkg::ENV_O2) - 32'(f1_time_reg))
                                               * 32'(ahts_pkg::ENV_S2));
        end else if (f1_time_reg < ahts_pkg::TIME_W'(ahts_pkg::ENV_T3)) begin
            f2_num_next = ahts_pkg::ENV_NUM_W'((32'(ahts_pkg::ENV_O3) - 32'(f1_time_reg))
                                               * 32'(ahts_pkg::ENV_S3));
        end else if (f1_time_reg < ahts_pkg::TIME_W'(ahts_pkg::ENV_T4)) begin
            f2_num_next = ahts_pkg::ENV_NUM_W'((32'(ahts_pkg::ENV_O4) - 32'(f1_time_reg))
                                               * 32'(ahts_pkg::ENV_S4));
        end else begin
            f2_num_next = '0;
        end
    end

    // The reciprocal product is at most one below the true quotient.
    always_comb begin
        logic [ahts_pkg::ENV_NUM_W+ahts_pkg::ENV_RCP_W-1:0] prod;
        prod = (ahts_pkg::ENV_NUM_W+ahts_pkg::ENV_RCP_W)'(f2_num_reg)
             * (ahts_pkg::ENV_NUM_W+ahts_pkg::ENV_RCP_W)'(ahts_pkg::ENV_RECIP);
        f3_quot_next = prod[ahts_pkg::ENV_SHIFT +: ahts_pkg::ENV_W];
    end

    always_comb begin
        f3_rem = (ahts_pkg::ENV_NUM_W+1)'(f3_num_reg)
               - (ahts_pkg::ENV_NUM_W+1)'(32'(f3_quot_reg) * 32'(ahts_pkg::ENV_DIV));
        if (f3_rem >= (ahts_pkg::ENV_NUM_W+1)'(ahts_pkg::ENV_DIV)) begin
            f4_env_next = f3_quot_reg + ahts_pkg::ENV_W'(1);
        end else begin
            f4_env_next = f3_quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_step_reg  <= s_freq_step;
            f1_level_reg <= s_level;
            f1_time_reg  <= s_note_time;

            f2_base_reg  <= ahts_pkg::FREQ_W'(f1_step_reg * ahts_pkg::FREQ_W'(f1_time_reg));
            f2_level_reg <= f1_level_reg;
            f2_num_reg   <= f2_num_next;

            f3_base_reg  <= f2_base_reg;
            f3_level_reg <= f2_level_reg;
            f3_num_reg   <= f2_num_reg;
            f3_quot_reg  <= f3_quot_next;

            f4_base_reg  <= f3_base_reg;
            f4_level_reg <= f3_level_reg;
            f4_env_reg   <= f4_env_next;
        end
    end

endmodule

### sv/ahts_queue.sv
// Short register queue that carries prepared notes from the front end to the back end.
module ahts_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ahts_pkg::note_t in_data,
    output logic            out_valid,
    input  logic            out_pop,
    output ahts_pkg::note_t out_data
);

    localparam int QD   = 2;
    localparam int QA_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    ahts_pkg::note_t   store_reg [QD];
    logic [QA_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   count_reg;
    logic              push, pop;

    assign in_ready  = count_reg != QC_W'(QD);
    assign out_valid = count_reg != '0;
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QA_W'(QD - 1)) ? '0 : wr_ptr_reg + QA_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QA_W'(QD - 1)) ? '0 : rd_ptr_reg + QA_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QC_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### sv/ahts_back.sv
// Back end: steps through the harmonics with one shared sine lookup, then scales and saturates.
module ahts_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                note_valid,
    output logic                                note_pop,
    input  ahts_pkg::note_t                     note_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ahts_pkg::SAMPLE_BITS-1:0]    m_sample
);

    localparam int PROD_W = ahts_pkg::MAG_W + ahts_pkg::WGT_W;
    localparam int ACC_W  = PROD_W + ahts_pkg::K_W + 1;
    localparam int Y1_W   = ACC_W - 16;
    localparam int P1_W   = Y1_W + ahts_pkg::LEVEL_W + 1;
    localparam int Y2_W   = P1_W - 16;
    localparam int P2_W   = Y2_W + ahts_pkg::ENV_W + 1;
    localparam int RS     = 32 - ahts_pkg::SAMPLE_BITS;
    localparam int Y3_W   = P2_W - RS;
    localparam logic signed [Y3_W-1:0] SAT_HI = Y3_W'((64'sd1 <<< (ahts_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Y3_W-1:0] SAT_LO = -SAT_HI - Y3_W'(1);

    logic en;
    logic load, last_issue;

    // Harmonic sequencer
    logic                              busy_reg;
    logic [ahts_pkg::K_W-1:0]          k_reg;
    logic [ahts_pkg::FREQ_W-1:0]       base_reg, ph_reg;
    logic [ahts_pkg::LEVEL_W-1:0]      lvl_reg;
    logic [ahts_pkg::ENV_W-1:0]        env_reg;

    // Issue stage
    logic                              s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [ahts_pkg::K_W-1:0]          s1_k_reg;
    logic [ahts_pkg::FREQ_W-1:0]       s1_ph_reg;
    logic [ahts_pkg::LEVEL_W-1:0]      s1_lvl_reg;
    logic [ahts_pkg::ENV_W-1:0]        s1_env_reg;

    // Sine lookup stage
    logic                              s2_valid_reg, s2_first_reg, s2_last_reg, s2_neg_reg;
    logic [ahts_pkg::MAG_W-1:0]        s2_mag_reg, s2_mag_next;
    logic [ahts_pkg::WGT_W-1:0]        s2_wgt_reg;
    logic [ahts_pkg::LEVEL_W-1:0]      s2_lvl_reg;
    logic [ahts_pkg::ENV_W-1:0]        s2_env_reg;

    // Accumulate stage
    logic                              s3_valid_reg, s3_last_reg;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic [ahts_pkg::LEVEL_W-1:0]      s3_lvl_reg;
    logic [ahts_pkg::ENV_W-1:0]        s3_env_reg;

    // Scaling stages
    logic                              s4_valid_reg, s5_valid_reg, m_valid_reg;
    logic signed [P1_W-1:0]            p1_reg, p1_next;
    logic [ahts_pkg::ENV_W-1:0]        s4_env_reg;
    logic signed [P2_W-1:0]            p2_reg, p2_next;
    logic [ahts_pkg::SAMPLE_BITS-1:0]  m_sample_reg, m_sample_next;

    logic [ahts_pkg::SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                           quad;
    logic [ahts_pkg::QIDX_W-1:0]          qr, qm;

    assign en         = !m_valid_reg || m_ready;
    assign last_issue = busy_reg && (k_reg == ahts_pkg::K_W'(ahts_pkg::NUM_HARMONICS - 1));
    assign load       = (!busy_reg || last_issue) && note_valid;
    assign note_pop   = en && load;
    assign m_valid    = m_valid_reg;
    assign m_sample   = m_sample_reg;

    // The table holds the first quarter wave; the peak entry sits one past its end.
    always_comb begin
        idx  = s1_ph_reg[ahts_pkg::FREQ_W-1 -: ahts_pkg::SINE_TABLE_BITS];
        quad = idx[ahts_pkg::SINE_TABLE_BITS-1 -: 2];
        qr   = idx[ahts_pkg::QIDX_W-1:0];
        qm   = quad[0] ? (~qr + ahts_pkg::QIDX_W'(1)) : qr;
        if (quad[0] && qr == '0) begin
            s2_mag_next = ahts_pkg::QSINE_TOP;
        end else begin
            s2_mag_next = ahts_pkg::QSINE[qm];
        end
    end

    always_comb begin
        logic [PROD_W-1:0]       prod;
        logic signed [ACC_W-1:0] term;
        prod = PROD_W'(s2_mag_reg) * PROD_W'(s2_wgt_reg);
        term = s2_neg_reg ? -$signed(ACC_W'(prod)) : $signed(ACC_W'(prod));
        acc_next = s2_first_reg ? term : acc_reg + term;
    end

    always_comb begin
        logic [ACC_W-1:0]       acc_rnd;
        logic signed [Y1_W-1:0] y1;
        acc_rnd = acc_reg + ACC_W'(1 << 15);
        y1      = acc_rnd[ACC_W-1:16];
        p1_next = P1_W'(y1) * $signed(P1_W'({1'b0, s3_lvl_reg}));
    end

    always_comb begin
        logic [P1_W-1:0]        p1_rnd;
        logic signed [Y2_W-1:0] y2;
        p1_rnd  = p1_reg + P1_W'(1 << 15);
        y2      = p1_rnd[P1_W-1:16];
        p2_next = P2_W'(y2) * $signed(P2_W'({1'b0, s4_env_reg}));
    end

    always_comb begin
        logic [P2_W-1:0]        p2_rnd;
        logic signed [Y3_W-1:0] y3;
        p2_rnd = p2_reg + P2_W'(64'd1 << (RS - 1));
        y3     = p2_rnd[P2_W-1:RS];
        if (y3 > SAT_HI) begin
            m_sample_next = SAT_HI[ahts_pkg::SAMPLE_BITS-1:0];
        end else if (y3 < SAT_LO) begin
            m_sample_next = SAT_LO[ahts_pkg::SAMPLE_BITS-1:0];
        end else begin
            m_sample_next = y3[ahts_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            if (load) begin
                busy_reg <= 1'b1;
            end else if (last_issue) begin
                busy_reg <= 1'b0;
            end
            s1_valid_reg <= busy_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && s3_last_reg;
            s5_valid_reg <= s4_valid_reg;
            m_valid_reg  <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (load) begin
                base_reg <= note_data.base;
                ph_reg   <= note_data.base;
                k_reg    <= '0;
                lvl_reg  <= note_data.level;
                env_reg  <= note_data.env;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + base_reg;
                k_reg  <= k_reg + ahts_pkg::K_W'(1);
            end

            s1_ph_reg    <= ph_reg;
            s1_k_reg     <= k_reg;
            s1_first_reg <= k_reg == '0;
            s1_last_reg  <= k_reg == ahts_pkg::K_W'(ahts_pkg::NUM_HARMONICS - 1);
            s1_lvl_reg   <= lvl_reg;
            s1_env_reg   <= env_reg;

            s2_mag_reg   <= s2_mag_next;
            s2_neg_reg   <= quad[1];
            s2_wgt_reg   <= ahts_pkg::WEIGHT_Q16[5'(s1_k_reg)];
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_lvl_reg   <= s1_lvl_reg;
            s2_env_reg   <= s1_env_reg;

            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            s3_last_reg  <= s2_last_reg;
            s3_lvl_reg   <= s2_lvl_reg;
            s3_env_reg   <= s2_env_reg;

            p1_reg       <= p1_next;
            s4_env_reg   <= s3_env_reg;
            p2_reg       <= p2_next;
            m_sample_reg <= m_sample_next;
        end
    end

endmodule

### sv/additive_harmonic_tone_sample_unit.sv
// The back end makes a single sine table read per harmonic and takes a new item only as it
// issues the last harmonic of the one before; the front end and its queue take items in any
// cycle in which the full queue and a stalled back end do not hold them up.
// The envelope divide and the fundamental phase product take four front-end stages.
// Reset (aresetn, synchronous, active low) empties the pipelines and the queue; no
// memory needs clearing, so items are taken in the first cycle after reset.
module additive_harmonic_tone_sample_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ahts_pkg::FREQ_W-1:0]        s_freq_step,
    input  logic [ahts_pkg::LEVEL_W-1:0]       s_level,
    input  logic [ahts_pkg::TIME_W-1:0]        s_note_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ahts_pkg::SAMPLE_BITS-1:0] m_sample
);

    logic            push_valid, push_ready;
    ahts_pkg::note_t push_data;
    logic            note_valid, note_pop;
    ahts_pkg::note_t note_data;
    logic [ahts_pkg::SAMPLE_BITS-1:0] sample_bits;

    assign m_sample = $signed(sample_bits);

    ahts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_freq_step (s_freq_step),
        .s_level     (s_level),
        .s_note_time (s_note_time),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    ahts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (note_valid),
        .out_pop   (note_pop),
        .out_data  (note_data)
    );

    ahts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .note_valid (note_valid),
        .note_pop   (note_pop),
        .note_data  (note_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (sample_bits)
    );

endmodule
